// ===== design/i2cm_pkg.sv =====
`default_nettype none
package i2cm_pkg;

	localparam int DEF_BUFFER_DEPTH = 32;
	localparam int DEF_CLEAR_PULSES = 10;
	localparam int DEF_CHECK_BITS   = 20;

	localparam logic [11:0] HALF_PERIOD_RESET = 12'd250;
	localparam logic [15:0] STRETCH_RESET     = 16'd690;

	typedef enum logic [2:0] {
		KIND_TICK  = 3'd0,
		KIND_LOAD  = 3'd1,
		KIND_WRITE = 3'd2,
		KIND_READ  = 3'd3,
		KIND_POP   = 3'd4,
		KIND_CHECK = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_LOAD,
		CMD_WRITE,
		CMD_READ,
		CMD_POP,
		CMD_CHECK
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BUSY      = 3'd1,
		ST_ADDR_NACK = 3'd2,
		ST_DATA_NACK = 3'd3,
		ST_SCL_LOW   = 3'd4,
		ST_SCL_STUCK = 3'd5,
		ST_SDA_LOW   = 3'd6,
		ST_SDA_START = 3'd7
	} status_t;

	localparam logic CFG_HALF_PERIOD = 1'b0;
	localparam logic CFG_STRETCH     = 1'b1;

	typedef struct packed {
		cmd_t       cmd;
		logic [6:0] addr;
		logic [5:0] count;
		logic       stop;
		logic [7:0] data;
		logic       scl;
		logic       sda;
	} item_t;

endpackage
`default_nettype wire

// ===== design/i2cm_front.sv =====
`default_nettype none
module i2cm_front
	import i2cm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] kind,
	input  wire logic [6:0] target_address,
	input  wire logic [5:0] byte_count,
	input  wire logic       send_stop,
	input  wire logic [7:0] tx_byte,
	input  wire logic       scl_in,
	input  wire logic       sda_in,
	output logic            q_valid,
	output item_t           q_item,
	input  wire logic       q_take
);

	item_t      slot_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	logic       wr_q;
	item_t      cls;
	logic       push;

	always_comb begin
		cls.addr  = target_address;
		cls.count = byte_count;
		cls.stop  = send_stop;
		cls.data  = tx_byte;
		cls.scl   = scl_in;
		cls.sda   = sda_in;
		unique case (kind)
			KIND_LOAD:  cls.cmd = CMD_LOAD;
			KIND_WRITE: cls.cmd = CMD_WRITE;
			KIND_READ:  cls.cmd = CMD_READ;
			KIND_POP:   cls.cmd = CMD_POP;
			KIND_CHECK: cls.cmd = CMD_CHECK;
			default:    cls.cmd = CMD_TICK;
		endcase
	end

	assign in_stall = cnt_q == 2'd2;
	assign push     = in_valid && !in_stall;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_take) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end

endmodule
`default_nettype wire

// ===== design/i2cm_back.sv =====
`default_nettype none
module i2cm_back
	import i2cm_pkg::*;
#(
	parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
	parameter int CLEAR_PULSES = DEF_CLEAR_PULSES,
	parameter int CHECK_BITS   = DEF_CHECK_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        q_valid,
	input  wire item_t       q_item,
	output logic             q_take,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             scl_low,
	output logic             sda_low,
	output logic             busy_res,
	output logic             done_res,
	output logic [2:0]       status,
	output logic [7:0]       rx_byte,
	output logic             rx_valid,
	output logic [5:0]       rx_available,
	output logic             tx_overflow
);

	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int AW = BUFFER_DEPTH > 1 ? $clog2(BUFFER_DEPTH) : 1;
	localparam int PW = $clog2(CLEAR_PULSES + 1);
	localparam int KW = $clog2(CHECK_BITS + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

	typedef enum logic [3:0] {
		PH_IDLE, PH_START_REL, PH_START_HOLD, PH_START_LOW, PH_BIT_LOW,
		PH_BIT_STRETCH, PH_BIT_HIGH, PH_STOP_LOW, PH_STOP_STRETCH, PH_STOP_HIGH,
		PH_STOP_REL, PH_CLR_CHECK, PH_CLR_LOW, PH_CLR_HIGH, PH_CHK_TEST
	} phase_t;

	typedef enum logic [1:0] {MODE_WRITE, MODE_READ, MODE_CHECK} mode_t;

	logic [11:0]   hp_q;
	logic [15:0]   stretch_q;
	phase_t        ph_q, ph_nx;
	logic [15:0]   dly_q, dly_nx;
	logic [3:0]    bit_q, bit_nx;
	logic [7:0]    sh_q, sh_nx;
	logic [CW-1:0] bidx_q, bidx_nx;
	logic [CW-1:0] txc_q, txc_nx;
	logic [CW-1:0] rxl_q, rxl_nx;
	logic [CW-1:0] rxr_q, rxr_nx;
	logic [2:0]    st_q, st_nx;
	logic          dscl_q, dscl_nx, dsda_q, dsda_nx;
	logic          stop_q, stop_nx, adr_q, adr_nx, smp_q, smp_nx;
	mode_t         mode_q, mode_nx;
	logic [6:0]    addr_q, addr_nx;
	logic [CW-1:0] rcnt_q, rcnt_nx;
	logic [2:0]    pend_q, pend_nx;
	logic [PW-1:0] pul_q, pul_nx;
	logic [KW-1:0] chk_q, chk_nx;

	logic [7:0] tx_mem [BUFFER_DEPTH];
	logic [7:0] rx_mem [BUFFER_DEPTH];
	logic [7:0] tx_pref_q, rx_pref_q;
	logic          tx_we, rx_we;
	logic [AW-1:0] tx_wa, rx_wa, tx_ra, rx_ra;
	logic [7:0]    tx_wd, rx_wd;

	logic        take;
	logic        done, rxv, ovf;
	logic [7:0]  rxb;
	logic [15:0] hpv;
	logic        exp_t;
	logic        f_begin, b_read, b_val;
	logic        f_finish, f_after_stop, f_complete, f_chkloop, f_nw, f_nr;
	logic [2:0]  fin_code, cmp_code;
	logic [CW-1:0] nidx;
	logic        chk_sda;
	logic [7:0]  ns;
	item_t       it;

	assign take   = q_valid && (!out_valid || !out_stall);
	assign q_take = take;
	assign it     = q_item;
	assign hpv    = hp_q == 12'd0 ? 16'd1 : {4'd0, hp_q};

	always_comb begin
		ph_nx = ph_q; dly_nx = dly_q; bit_nx = bit_q; sh_nx = sh_q; bidx_nx = bidx_q;
		txc_nx = txc_q; rxl_nx = rxl_q; rxr_nx = rxr_q; st_nx = st_q;
		dscl_nx = dscl_q; dsda_nx = dsda_q; stop_nx = stop_q; adr_nx = adr_q;
		smp_nx = smp_q; mode_nx = mode_q; addr_nx = addr_q; rcnt_nx = rcnt_q;
		pend_nx = pend_q; pul_nx = pul_q; chk_nx = chk_q;
		done = 1'b0; rxv = 1'b0; ovf = 1'b0; rxb = 8'd0;
		tx_we = 1'b0; tx_wa = txc_q[AW-1:0]; tx_wd = it.data;
		rx_we = 1'b0; rx_wa = bidx_q[AW-1:0]; rx_wd = 8'd0;
		f_begin = 1'b0; b_read = 1'b0; b_val = 1'b0;
		f_finish = 1'b0; f_after_stop = 1'b0; f_complete = 1'b0; f_chkloop = 1'b0;
		f_nw = 1'b0; f_nr = 1'b0;
		fin_code = ST_OK; cmp_code = ST_OK; nidx = bidx_q; chk_sda = it.sda; ns = 8'd0;
		exp_t = dly_q <= 16'd1;
		if (take) begin
			if (ph_q != PH_IDLE) begin
				if (ph_q != PH_BIT_STRETCH && ph_q != PH_STOP_STRETCH && dly_q != 16'd0) begin
					dly_nx = dly_q - 16'd1;
				end
				unique case (ph_q)
					PH_START_REL: begin
						if (!it.sda) begin
							f_complete = 1'b1;
							cmp_code = mode_q == MODE_CHECK ? ST_SDA_START : ST_BUSY;
						end else begin
							ph_nx = PH_START_HOLD; dscl_nx = 1'b0; dsda_nx = 1'b0; dly_nx = hpv;
						end
					end
					PH_START_HOLD: if (exp_t) begin
						ph_nx = PH_START_LOW; dscl_nx = 1'b0; dsda_nx = 1'b1; dly_nx = hpv;
					end
					PH_START_LOW: if (exp_t) begin
						if (mode_q == MODE_CHECK) begin
							f_complete = 1'b1; cmp_code = ST_OK;
						end else begin
							sh_nx = {addr_q, mode_q == MODE_READ};
							adr_nx = 1'b1; bit_nx = 4'd0;
							f_begin = 1'b1; b_val = addr_q[6];
						end
					end
					PH_BIT_LOW: if (exp_t) begin
						ph_nx = PH_BIT_STRETCH; dscl_nx = 1'b0; dly_nx = 16'd0;
					end
					PH_BIT_STRETCH: begin
						if (it.scl || dly_q >= stretch_q) begin
							smp_nx = it.sda; ph_nx = PH_BIT_HIGH; dscl_nx = 1'b0; dly_nx = hpv;
						end else begin
							dly_nx = dly_q + 16'd1;
						end
					end
					PH_BIT_HIGH: if (exp_t) begin
						if (mode_q == MODE_CHECK) begin
							ph_nx = PH_CHK_TEST; dly_nx = 16'd1;
						end else if (mode_q == MODE_READ && !adr_q) begin
							if (bit_q < 4'd8) begin
								ns = {sh_q[6:0], smp_q};
								sh_nx = ns; bit_nx = bit_q + 4'd1;
								if (bit_q + 4'd1 < 4'd8) begin
									f_begin = 1'b1; b_read = 1'b1;
								end else begin
									if (bidx_q < DEPTH_C) begin
										rx_we = 1'b1; rx_wd = ns;
									end
									f_begin = 1'b1;
									b_val = {1'b0, bidx_q} + 1'b1 >= {1'b0, rcnt_q};
								end
							end else begin
								nidx = bidx_q + 1'b1; bidx_nx = nidx; f_nr = 1'b1;
							end
						end else if (bit_q < 4'd7) begin
							ns = {sh_q[6:0], 1'b0};
							sh_nx = ns; bit_nx = bit_q + 4'd1;
							f_begin = 1'b1; b_val = ns[7];
						end else if (bit_q == 4'd7) begin
							bit_nx = 4'd8; f_begin = 1'b1; b_read = 1'b1;
						end else if (smp_q) begin
							f_finish = 1'b1; fin_code = adr_q ? ST_ADDR_NACK : ST_DATA_NACK;
						end else if (adr_q) begin
							adr_nx = 1'b0; nidx = '0; bidx_nx = '0;
							if (mode_q == MODE_WRITE) f_nw = 1'b1;
							else f_nr = 1'b1;
						end else begin
							nidx = bidx_q + 1'b1; bidx_nx = nidx; f_nw = 1'b1;
						end
					end
					PH_STOP_LOW: if (exp_t) begin
						ph_nx = PH_STOP_STRETCH; dscl_nx = 1'b0; dsda_nx = 1'b1; dly_nx = 16'd0;
					end
					PH_STOP_STRETCH: begin
						if (it.scl || dly_q >= stretch_q) begin
							ph_nx = PH_STOP_HIGH; dscl_nx = 1'b0; dsda_nx = 1'b1; dly_nx = hpv;
						end else begin
							dly_nx = dly_q + 16'd1;
						end
					end
					PH_STOP_HIGH: if (exp_t) begin
						ph_nx = PH_STOP_REL; dscl_nx = 1'b0; dsda_nx = 1'b0; dly_nx = hpv;
					end
					PH_STOP_REL: if (exp_t) f_after_stop = 1'b1;
					PH_CLR_CHECK: begin
						if (!it.sda && pul_q < PW'(CLEAR_PULSES)) begin
							pul_nx = pul_q + 1'b1; ph_nx = PH_CLR_LOW; dscl_nx = 1'b1; dly_nx = hpv;
						end else begin
							f_complete = 1'b1; cmp_code = ST_OK;
						end
					end
					PH_CLR_LOW: if (exp_t) begin
						ph_nx = PH_CLR_HIGH; dscl_nx = 1'b0; dly_nx = hpv;
					end
					PH_CLR_HIGH: if (exp_t) begin
						ph_nx = PH_CLR_CHECK; dscl_nx = 1'b0; dly_nx = 16'd1;
					end
					PH_CHK_TEST: begin
						if (!it.scl) begin
							f_complete = 1'b1; cmp_code = ST_SCL_STUCK;
						end else begin
							f_chkloop = 1'b1;
						end
					end
					default: ph_nx = PH_IDLE;
				endcase
			end else begin
				unique case (it.cmd)
					CMD_LOAD: begin
						if (txc_q < DEPTH_C) begin
							tx_we = 1'b1; txc_nx = txc_q + 1'b1;
						end else begin
							ovf = 1'b1;
						end
					end
					CMD_WRITE, CMD_READ: begin
						mode_nx = it.cmd == CMD_WRITE ? MODE_WRITE : MODE_READ;
						addr_nx = it.addr;
						rcnt_nx = int'(it.count) > BUFFER_DEPTH ? DEPTH_C : CW'(it.count);
						stop_nx = it.stop;
						bidx_nx = '0; st_nx = ST_BUSY;
						if (it.cmd == CMD_READ) begin
							rxl_nx = '0; rxr_nx = '0;
						end
						ph_nx = PH_START_REL; dscl_nx = 1'b0; dsda_nx = 1'b0; dly_nx = 16'd1;
					end
					CMD_POP: begin
						if (rxr_q < rxl_q && rxr_q < DEPTH_C) begin
							rxb = rx_pref_q; rxv = 1'b1; rxr_nx = rxr_q + 1'b1;
						end
					end
					CMD_CHECK: begin
						mode_nx = MODE_CHECK;
						if (!it.scl) begin
							st_nx = ST_SCL_LOW; done = 1'b1;
						end else begin
							chk_nx = KW'(CHECK_BITS); st_nx = ST_BUSY; f_chkloop = 1'b1;
						end
					end
					default: ;
				endcase
			end

			if (f_chkloop) begin
				if (!chk_sda && chk_nx != '0) begin
					chk_nx = chk_nx - 1'b1; f_begin = 1'b1; b_read = 1'b1;
				end else if (!chk_sda) begin
					f_complete = 1'b1; cmp_code = ST_SDA_LOW;
				end else begin
					ph_nx = PH_START_REL; dscl_nx = 1'b0; dsda_nx = 1'b0; dly_nx = 16'd1;
				end
			end
			if (f_nw) begin
				if (nidx < txc_q && nidx < DEPTH_C) begin
					sh_nx = tx_pref_q; bit_nx = 4'd0; f_begin = 1'b1; b_val = tx_pref_q[7];
				end else begin
					f_finish = 1'b1; fin_code = ST_OK;
				end
			end
			if (f_nr) begin
				if (nidx < rcnt_q) begin
					sh_nx = 8'd0; bit_nx = 4'd0; f_begin = 1'b1; b_read = 1'b1;
				end else begin
					f_finish = 1'b1; fin_code = ST_OK;
				end
			end
			if (f_finish) begin
				pend_nx = fin_code;
				if (stop_q) begin
					ph_nx = PH_STOP_LOW; dscl_nx = 1'b1; dsda_nx = 1'b1; dly_nx = hpv;
				end else begin
					f_after_stop = 1'b1;
				end
			end
			if (f_after_stop) begin
				if (pend_nx == ST_OK) begin
					pul_nx = '0; ph_nx = PH_CLR_CHECK; dly_nx = 16'd1;
				end else begin
					f_complete = 1'b1; cmp_code = pend_nx;
				end
			end
			if (f_begin) begin
				ph_nx = PH_BIT_LOW; dscl_nx = 1'b1;
				dsda_nx = b_read ? 1'b0 : !b_val;
				dly_nx = hpv + (b_read ? 16'd2 : 16'd1);
			end
			if (f_complete) begin
				ph_nx = PH_IDLE; st_nx = cmp_code; done = 1'b1;
				if (mode_q == MODE_WRITE) txc_nx = '0;
				if (mode_q == MODE_READ) begin
					rxl_nx = cmp_code == ST_OK ? rcnt_q : '0;
					rxr_nx = '0;
				end
			end
		end
		tx_ra = adr_nx ? bidx_nx[AW-1:0] : AW'(bidx_nx + 1'b1);
		rx_ra = rxr_nx[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (tx_we) tx_mem[tx_wa] <= tx_wd;
		if (rx_we) rx_mem[rx_wa] <= rx_wd;
		tx_pref_q <= (tx_we && tx_wa == tx_ra) ? tx_wd : tx_mem[tx_ra];
		rx_pref_q <= (rx_we && rx_wa == rx_ra) ? rx_wd : rx_mem[rx_ra];
		sh_q   <= sh_nx;
		addr_q <= addr_nx;
		if (take) begin
			rx_byte <= rxb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q <= HALF_PERIOD_RESET; stretch_q <= STRETCH_RESET;
			ph_q <= PH_IDLE; dly_q <= '0; bit_q <= '0; bidx_q <= '0;
			txc_q <= '0; rxl_q <= '0; rxr_q <= '0; st_q <= ST_OK;
			dscl_q <= 1'b0; dsda_q <= 1'b0; stop_q <= 1'b0; adr_q <= 1'b0;
			smp_q <= 1'b0; mode_q <= MODE_WRITE; rcnt_q <= '0; pend_q <= ST_OK;
			pul_q <= '0; chk_q <= '0;
			out_valid <= 1'b0; busy_res <= 1'b0; done_res <= 1'b0; status <= ST_OK;
			scl_low <= 1'b0; sda_low <= 1'b0; rx_valid <= 1'b0; rx_available <= '0;
			tx_overflow <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_HALF_PERIOD) hp_q <= cfg_data[11:0];
				else stretch_q <= cfg_data;
			end
			ph_q <= ph_nx; dly_q <= dly_nx; bit_q <= bit_nx; bidx_q <= bidx_nx;
			txc_q <= txc_nx; rxl_q <= rxl_nx; rxr_q <= rxr_nx; st_q <= st_nx;
			dscl_q <= dscl_nx; dsda_q <= dsda_nx; stop_q <= stop_nx; adr_q <= adr_nx;
			smp_q <= smp_nx; mode_q <= mode_nx; rcnt_q <= rcnt_nx; pend_q <= pend_nx;
			pul_q <= pul_nx; chk_q <= chk_nx;
			out_valid <= take || (out_valid && out_stall);
			if (take) begin
				scl_low      <= dscl_nx;
				sda_low      <= dsda_nx;
				busy_res     <= ph_nx != PH_IDLE;
				done_res     <= done;
				status       <= st_nx;
				rx_valid     <= rxv;
				rx_available <= 6'(rxl_nx - rxr_nx);
				tx_overflow  <= ovf;
			end
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && busy_res)) else $error("done while busy");
	a_tx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		txc_q <= DEPTH_C) else $error("tx count overrun");
	a_rx_order: assert property (@(posedge clk) disable iff (!arst_n)
		rxr_q <= rxl_q) else $error("rx read past length");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take && rxv |-> ph_q == PH_IDLE) else $error("pop during transfer");

endmodule
`default_nettype wire

// ===== design/i2c_master_transfer_engine_core.sv =====
// Each item is one bus tick run by the back-end sequencer into its output register.
// Throughput: one item per cycle while the output is not stalled.
// A two-entry queue between front and back absorbs output stalls.
// Reset (arst_n low, asynchronous): lines released, idle, buffers empty, status 0,
// half period 250 and stretch limit 690 ticks.
`default_nettype none
module i2c_master_transfer_engine_core
	import i2cm_pkg::*;
#(
	parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
	parameter int CLEAR_PULSES = DEF_CLEAR_PULSES,
	parameter int CHECK_BITS   = DEF_CHECK_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [6:0]  target_address,
	input  wire logic [5:0]  byte_count,
	input  wire logic        send_stop,
	input  wire logic [7:0]  tx_byte,
	input  wire logic        scl_in,
	input  wire logic        sda_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             scl_low,
	output logic             sda_low,
	output logic             busy_res,
	output logic             done_res,
	output logic [2:0]       status,
	output logic [7:0]       rx_byte,
	output logic             rx_valid,
	output logic [5:0]       rx_available,
	output logic             tx_overflow
);

	logic  q_valid;
	logic  q_take;
	item_t q_item;

	i2cm_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .target_address, .byte_count,
		.send_stop, .tx_byte, .scl_in, .sda_in, .q_valid, .q_item, .q_take
	);

	i2cm_back #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.CLEAR_PULSES(CLEAR_PULSES),
		.CHECK_BITS(CHECK_BITS)
	) u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_item, .q_take,
		.out_valid, .out_stall, .scl_low, .sda_low, .busy_res, .done_res, .status,
		.rx_byte, .rx_valid, .rx_available, .tx_overflow
	);

endmodule
`default_nettype wire

// ===== tb/i2cm_checker.sv =====
module i2cm_checker
	import i2cm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [6:0]  target_address,
	input  wire logic [5:0]  byte_count,
	input  wire logic        send_stop,
	input  wire logic [7:0]  tx_byte,
	input  wire logic        scl_in,
	input  wire logic        sda_in,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        scl_low,
	input  wire logic        sda_low,
	input  wire logic        busy_res,
	input  wire logic        done_res,
	input  wire logic [2:0]  status,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        rx_valid,
	input  wire logic [5:0]  rx_available,
	input  wire logic        tx_overflow,
	output int               fails,
	output int               pending,
	output int               results_seen,
	output int               ops_done
);

	localparam int DEPTH  = DEF_BUFFER_DEPTH;
	localparam int PULSES = DEF_CLEAR_PULSES;
	localparam int CHECKS = DEF_CHECK_BITS;

	typedef enum {
		P_IDLE, P_START_REL, P_START_HOLD, P_START_LOW, P_BIT_LOW, P_BIT_STRETCH,
		P_BIT_HIGH, P_STOP_LOW, P_STOP_STRETCH, P_STOP_HIGH, P_STOP_REL,
		P_CLR_CHECK, P_CLR_LOW, P_CLR_HIGH, P_CHK_TEST
	} seq_phase_t;

	typedef enum {M_WRITE, M_READ, M_CHECK} xfer_mode_t;

	typedef struct packed {
		logic       scl_l;
		logic       sda_l;
		logic       busy;
		logic       done;
		logic [2:0] st;
		logic [7:0] rxb;
		logic       rxv;
		logic [5:0] avail;
		logic       ovf;
	} bus_result_t;

	bus_result_t result_q[$];

	int unsigned half_ticks, stretch_ticks;
	seq_phase_t  phase;
	xfer_mode_t  mode;
	int unsigned delay_cnt, bit_cnt, shifter, byte_idx;
	logic [7:0]  tx_store[DEPTH];
	logic [7:0]  rx_store[DEPTH];
	int unsigned tx_count, rx_length, rx_index, read_count, pulse_cnt, checks_left;
	int unsigned addr_l;
	status_t     result_status, pend_code;
	bit          drv_scl, drv_sda, stop_l, addressing, sampled, done_now;

	function void reset_model();
		half_ticks = HALF_PERIOD_RESET;
		stretch_ticks = STRETCH_RESET;
		phase = P_IDLE;
		mode = M_WRITE;
		delay_cnt = 0; bit_cnt = 0; shifter = 0; byte_idx = 0;
		tx_count = 0; rx_length = 0; rx_index = 0; read_count = 0;
		pulse_cnt = 0; checks_left = 0; addr_l = 0;
		result_status = ST_OK; pend_code = ST_OK;
		drv_scl = 0; drv_sda = 0; stop_l = 0; addressing = 0; sampled = 0; done_now = 0;
	endfunction

	function int unsigned hp();
		return (half_ticks != 0) ? half_ticks : 1;
	endfunction

	function void go(seq_phase_t ph, bit sl, bit dl, int unsigned wait_ticks);
		phase = ph;
		drv_scl = sl;
		drv_sda = dl;
		delay_cnt = (wait_ticks != 0) ? wait_ticks : 1;
	endfunction

	function void begin_bit(bit is_read, bit value);
		go(P_BIT_LOW, 1'b1, is_read ? 1'b0 : !value, hp() + (is_read ? 2 : 1));
	endfunction

	function void complete(status_t code);
		phase = P_IDLE;
		result_status = code;
		done_now = 1;
		if (mode == M_WRITE)
			tx_count = 0;
		if (mode == M_READ) begin
			rx_length = (code == ST_OK) ? read_count : 0;
			rx_index = 0;
		end
	endfunction

	function void after_stop();
		if (pend_code == ST_OK) begin
			pulse_cnt = 0;
			go(P_CLR_CHECK, drv_scl, drv_sda, 1);
		end else
			complete(pend_code);
	endfunction

	function void finish_xfer(status_t code);
		pend_code = code;
		if (stop_l)
			go(P_STOP_LOW, 1'b1, 1'b1, hp());
		else
			after_stop();
	endfunction

	function void next_write();
		if (byte_idx < tx_count && byte_idx < DEPTH) begin
			shifter = tx_store[byte_idx];
			bit_cnt = 0;
			begin_bit(1'b0, shifter[7]);
		end else
			finish_xfer(ST_OK);
	endfunction

	function void next_read();
		if (byte_idx < read_count) begin
			shifter = 0;
			bit_cnt = 0;
			begin_bit(1'b1, 1'b0);
		end else
			finish_xfer(ST_OK);
	endfunction

	function void after_start();
		if (mode == M_CHECK) begin
			complete(ST_OK);
			return;
		end
		shifter = ((addr_l << 1) | (mode == M_READ ? 1 : 0)) & 8'hFF;
		addressing = 1;
		bit_cnt = 0;
		begin_bit(1'b0, shifter[7]);
	endfunction

	function void check_loop(bit sda);
		if (!sda && checks_left > 0) begin
			checks_left--;
			begin_bit(1'b1, 1'b0);
		end else if (!sda)
			complete(ST_SDA_LOW);
		else
			go(P_START_REL, 1'b0, 1'b0, 1);
	endfunction

	function void after_bit(bit s);
		if (mode == M_CHECK) begin
			go(P_CHK_TEST, drv_scl, drv_sda, 1);
			return;
		end
		if (mode == M_READ && !addressing) begin
			if (bit_cnt < 8) begin
				shifter = ((shifter << 1) | s) & 8'hFF;
				bit_cnt++;
				if (bit_cnt < 8)
					begin_bit(1'b1, 1'b0);
				else begin
					if (byte_idx < DEPTH)
						rx_store[byte_idx] = shifter[7:0];
					begin_bit(1'b0, byte_idx + 1 >= read_count);
				end
			end else begin
				byte_idx++;
				next_read();
			end
			return;
		end
		if (bit_cnt < 7) begin
			shifter = (shifter << 1) & 8'hFF;
			bit_cnt++;
			begin_bit(1'b0, shifter[7]);
		end else if (bit_cnt == 7) begin
			bit_cnt = 8;
			begin_bit(1'b1, 1'b0);
		end else if (s)
			finish_xfer(addressing ? ST_ADDR_NACK : ST_DATA_NACK);
		else if (addressing) begin
			addressing = 0;
			byte_idx = 0;
			if (mode == M_WRITE)
				next_write();
			else
				next_read();
		end else begin
			byte_idx++;
			next_write();
		end
	endfunction

	function bit expired();
		if (delay_cnt > 0)
			delay_cnt--;
		return delay_cnt == 0;
	endfunction

	function void run_phase(bit scl, bit sda);
		case (phase)
			P_START_REL: begin
				if (!sda)
					complete(mode == M_CHECK ? ST_SDA_START : ST_BUSY);
				else
					go(P_START_HOLD, 1'b0, 1'b0, hp());
			end
			P_START_HOLD: if (expired()) go(P_START_LOW, 1'b0, 1'b1, hp());
			P_START_LOW: if (expired()) after_start();
			P_BIT_LOW: begin
				if (expired()) begin
					go(P_BIT_STRETCH, 1'b0, drv_sda, 1);
					delay_cnt = 0;
				end
			end
			P_BIT_STRETCH: begin
				if (scl || delay_cnt >= stretch_ticks) begin
					sampled = sda;
					go(P_BIT_HIGH, 1'b0, drv_sda, hp());
				end else
					delay_cnt++;
			end
			P_BIT_HIGH: if (expired()) after_bit(sampled);
			P_STOP_LOW: begin
				if (expired()) begin
					go(P_STOP_STRETCH, 1'b0, 1'b1, 1);
					delay_cnt = 0;
				end
			end
			P_STOP_STRETCH: begin
				if (scl || delay_cnt >= stretch_ticks)
					go(P_STOP_HIGH, 1'b0, 1'b1, hp());
				else
					delay_cnt++;
			end
			P_STOP_HIGH: if (expired()) go(P_STOP_REL, 1'b0, 1'b0, hp());
			P_STOP_REL: if (expired()) after_stop();
			P_CLR_CHECK: begin
				if (!sda && pulse_cnt < PULSES) begin
					pulse_cnt++;
					go(P_CLR_LOW, 1'b1, drv_sda, hp());
				end else
					complete(ST_OK);
			end
			P_CLR_LOW: if (expired()) go(P_CLR_HIGH, 1'b0, drv_sda, hp());
			P_CLR_HIGH: if (expired()) go(P_CLR_CHECK, 1'b0, drv_sda, 1);
			P_CHK_TEST: begin
				if (!scl)
					complete(ST_SCL_STUCK);
				else
					check_loop(sda);
			end
			default: phase = P_IDLE;
		endcase
	endfunction

	function bus_result_t predict_tick(logic [2:0] k, logic [6:0] addr, logic [5:0] cnt,
			logic stp, logic [7:0] txb, logic scl, logic sda);
		bus_result_t r;
		r = '0;
		done_now = 0;
		if (phase != P_IDLE)
			run_phase(scl, sda);
		else if (k == KIND_LOAD) begin
			if (tx_count < DEPTH) begin
				tx_store[tx_count] = txb;
				tx_count++;
			end else
				r.ovf = 1;
		end else if (k == KIND_WRITE || k == KIND_READ) begin
			mode = (k == KIND_WRITE) ? M_WRITE : M_READ;
			addr_l = addr;
			read_count = (cnt > DEPTH) ? DEPTH : cnt;
			stop_l = stp;
			byte_idx = 0;
			result_status = ST_BUSY;
			if (mode == M_READ) begin
				rx_length = 0;
				rx_index = 0;
			end
			go(P_START_REL, 1'b0, 1'b0, 1);
		end else if (k == KIND_POP) begin
			if (rx_index < rx_length && rx_index < DEPTH) begin
				r.rxb = rx_store[rx_index];
				rx_index++;
				r.rxv = 1;
			end
		end else if (k == KIND_CHECK) begin
			mode = M_CHECK;
			if (!scl) begin
				result_status = ST_SCL_LOW;
				done_now = 1;
			end else begin
				checks_left = CHECKS;
				result_status = ST_BUSY;
				check_loop(sda);
			end
		end
		r.scl_l = drv_scl;
		r.sda_l = drv_sda;
		r.busy = (phase != P_IDLE);
		r.done = done_now;
		r.st = result_status;
		r.avail = (rx_length >= rx_index) ? rx_length - rx_index : 0;
		return r;
	endfunction

	function void check_field(string nm, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", nm, exp_v, act_v);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bus_result_t e;
		if (!arst_n) begin
			reset_model();
			result_q.delete();
			fails = 0;
			pending = 0;
			results_seen = 0;
			ops_done = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_HALF_PERIOD)
					half_ticks = cfg_data[11:0];
				else
					stretch_ticks = cfg_data;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (result_q.size() == 0) begin
					$error("result with no pending transfer");
					fails++;
				end else begin
					e = result_q.pop_front();
					check_field("scl_low", e.scl_l, scl_low);
					check_field("sda_low", e.sda_l, sda_low);
					check_field("busy_res", e.busy, busy_res);
					check_field("done_res", e.done, done_res);
					check_field("status", e.st, status);
					check_field("rx_byte", e.rxb, rx_byte);
					check_field("rx_valid", e.rxv, rx_valid);
					check_field("rx_available", e.avail, rx_available);
					check_field("tx_overflow", e.ovf, tx_overflow);
					if (done_res)
						ops_done++;
				end
			end
			if (in_valid && !in_stall)
				result_q.push_back(predict_tick(kind, target_address, byte_count,
					send_stop, tx_byte, scl_in, sda_in));
			pending = result_q.size();
		end
	end

endmodule

// ===== tb/tb_i2c_master_transfer_engine_core.sv =====
module tb_i2c_master_transfer_engine_core;
	import i2cm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  kind;
	logic [6:0]  target_address;
	logic [5:0]  byte_count;
	logic        send_stop;
	logic [7:0]  tx_byte;
	logic        scl_in;
	logic        sda_in;
	logic        out_valid;
	logic        out_stall;
	logic        scl_low;
	logic        sda_low;
	logic        busy_res;
	logic        done_res;
	logic [2:0]  status;
	logic [7:0]  rx_byte;
	logic        rx_valid;
	logic [5:0]  rx_available;
	logic        tx_overflow;

	int fails, pending, results_seen, ops_done;
	int items, burst_left, scl_low_pct, sda_low_pct, cyc, hold_left;

	i2c_master_transfer_engine_core DUT (.*);

	i2cm_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#50_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		cyc = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == 600)
				hold_left = 400;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else case ((cyc / 97) % 3)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 99) < 30);
				default: out_stall <= ($urandom_range(0, 99) < 70);
			endcase
		end
	end

	function logic pin_scl();
		return $urandom_range(0, 99) >= scl_low_pct;
	endfunction

	function logic pin_sda();
		return $urandom_range(0, 99) >= sda_low_pct;
	endfunction

	task send(logic [2:0] k, logic [6:0] a, logic [5:0] n, logic s, logic [7:0] b,
			logic scl, logic sda);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		kind <= k;
		target_address <= a;
		byte_count <= n;
		send_stop <= s;
		tx_byte <= b;
		scl_in <= scl;
		sda_in <= sda;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
		items++;
		@(negedge clk);
	endtask

	task ticks(int n);
		repeat (n)
			send(KIND_TICK, 7'($urandom), 6'($urandom), 1'($urandom), 8'($urandom),
				pin_scl(), pin_sda());
	endtask

	task wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task write_cfg(logic idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task run_sequence();
		int r, k;
		r = $urandom_range(0, 99);
		scl_low_pct = $urandom_range(0, 3) == 0 ? $urandom_range(5, 40) : 0;
		case ($urandom_range(0, 2))
			0: sda_low_pct = 10;
			1: sda_low_pct = 50;
			default: sda_low_pct = 90;
		endcase
		if (r < 10)
			send(3'($urandom), 7'($urandom), 6'($urandom), 1'($urandom), 8'($urandom),
				1'($urandom), 1'($urandom));
		else if (r < 35) begin
			k = $urandom_range(0, 3);
			repeat (k)
				send(KIND_LOAD, 7'($urandom), 6'($urandom), 1'($urandom), 8'($urandom),
					1'b1, 1'b1);
			send(KIND_WRITE, 7'($urandom), 6'($urandom), 1'($urandom), 8'($urandom),
				1'b1, 1'b1);
			ticks($urandom_range(20, 200));
		end else if (r < 60) begin
			k = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 63) : $urandom_range(0, 3);
			send(KIND_READ, 7'($urandom), 6'(k), 1'($urandom), 8'($urandom), 1'b1, 1'b1);
			ticks($urandom_range(20, 200));
		end else if (r < 75)
			repeat ($urandom_range(1, 4))
				send(KIND_POP, 7'($urandom), 6'($urandom), 1'($urandom), 8'($urandom),
					pin_scl(), pin_sda());
		else if (r < 90) begin
			send(KIND_CHECK, 7'($urandom), 6'($urandom), 1'($urandom), 8'($urandom),
				pin_scl(), pin_sda());
			ticks($urandom_range(10, 100));
		end else
			ticks($urandom_range(1, 20));
	endtask

	initial begin
		int hp_set[6];
		int st_set[6];
		int start_items;
		hp_set = '{0, 1, 2, 3, 1, 4};
		st_set = '{0, 65535, 3, 1, 20, 0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_HALF_PERIOD;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_TICK;
		target_address = '0;
		byte_count = '0;
		send_stop = 1'b0;
		tx_byte = '0;
		scl_in = 1'b1;
		sda_in = 1'b1;
		items = 0;
		burst_left = 0;
		scl_low_pct = 0;
		sda_low_pct = 50;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_cfg(CFG_HALF_PERIOD, 16'd1);
		write_cfg(CFG_STRETCH, 16'd4);
		send(KIND_POP, 7'h00, 6'd0, 1'b0, 8'h00, 1'b1, 1'b1);
		for (int i = 0; i < 33; i++)
			send(KIND_LOAD, 7'h00, 6'd0, 1'b0, (i % 2) ? 8'hFF : 8'h00, 1'b1, 1'b1);
		send(KIND_WRITE, 7'h7F, 6'd0, 1'b1, 8'h00, 1'b1, 1'b1);
		sda_low_pct = 100;
		ticks(30);
		send(KIND_LOAD, 7'h00, 6'd0, 1'b0, 8'hA5, 1'b1, 1'b1);
		sda_low_pct = 50;
		ticks(150);
		send(KIND_READ, 7'h00, 6'd0, 1'b0, 8'h00, 1'b1, 1'b1);
		ticks(60);
		send(KIND_READ, 7'h2A, 6'd63, 1'b1, 8'h00, 1'b1, 1'b1);
		ticks(200);
		send(KIND_CHECK, 7'h00, 6'd0, 1'b0, 8'h00, 1'b0, 1'b1);
		send(KIND_CHECK, 7'h00, 6'd0, 1'b0, 8'h00, 1'b1, 1'b0);
		ticks(100);
		send(3'd6, 7'h7F, 6'd63, 1'b1, 8'hFF, 1'b0, 1'b0);
		send(3'd7, 7'h7F, 6'd63, 1'b1, 8'hFF, 1'b1, 1'b1);
		repeat (4)
			send(KIND_POP, 7'h00, 6'd0, 1'b0, 8'h00, 1'b1, 1'b1);
		ticks(50);

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			write_cfg(CFG_HALF_PERIOD, 16'(hp_set[p]));
			write_cfg(CFG_STRETCH, 16'(st_set[p]));
			start_items = items;
			while (items - start_items < 100)
				run_sequence();
		end

		wait_idle();
		write_cfg(CFG_HALF_PERIOD, 16'd4095);
		write_cfg(CFG_STRETCH, 16'd65535);
		scl_low_pct = 0;
		sda_low_pct = 50;
		send(KIND_READ, 7'h55, 6'd0, 1'b1, 8'h00, 1'b1, 1'b1);
		ticks(200);
		wait_idle();
		write_cfg(CFG_HALF_PERIOD, 16'd2);
		write_cfg(CFG_STRETCH, 16'd10);
		repeat (4)
			run_sequence();

		wait_idle();
		repeat (10) @(negedge clk);
		$display("Ran %0d bus ticks, checked %0d results, %0d transfers and bus checks finished",
			items, results_seen, ops_done);
		$display("Covered half periods 0 to 4095, stretch limits 0 to 65535, all commands");
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== i2c_master_transfer_engine_core.f =====
design/i2cm_pkg.sv
design/i2cm_front.sv
design/i2cm_back.sv
design/i2c_master_transfer_engine_core.sv
tb/i2cm_checker.sv
tb/tb_i2c_master_transfer_engine_core.sv
